@@ rtl/core/ecpa_pkg.sv @@
// Package for the elliptic-curve point adder: field width, register
// indexes, reset values and the packed payload types of both channels.
// No dependencies.
`timescale 1ns / 1ps

package ecpa_pkg;

  localparam int FIELD_WIDTH     = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = CFG_INDEX_WIDTH'(0);
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_CURVE_A = CFG_INDEX_WIDTH'(1);

  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET = FIELD_WIDTH'(17);
  localparam logic [FIELD_WIDTH-1:0] CURVE_A_RESET = FIELD_WIDTH'(2);
  localparam logic [FIELD_WIDTH-1:0] MODULUS_MIN   = FIELD_WIDTH'(3);

  typedef struct packed {
    logic                   first_infinity;
    logic [FIELD_WIDTH-1:0] first_x;
    logic [FIELD_WIDTH-1:0] first_y;
    logic                   second_infinity;
    logic [FIELD_WIDTH-1:0] second_x;
    logic [FIELD_WIDTH-1:0] second_y;
  } ecpa_in_t;

  typedef struct packed {
    logic                   sum_infinity;
    logic [FIELD_WIDTH-1:0] sum_x;
    logic [FIELD_WIDTH-1:0] sum_y;
  } ecpa_out_t;

endpackage

@@ rtl/core/ec_point_add_prime_field.sv @@
// Affine point addition on a short Weierstrass curve over a prime field.
// Uses ecpa_pkg for the field width, register codes and payload structs.
//
//   channel | ports                                     | transaction when
//   --------+-------------------------------------------+------------------------
//   input   | in_valid, in_stall, in_data               | in_valid && !in_stall
//   result  | out_valid, out_stall, out_data            | out_valid && !out_stall
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One bit-serial modular step unit does every multiply and, paired with a
// restoring divider step, each extended-Euclid iteration. in_stall stays high
// while an input is processed: the case split alone may give the sum; a chord
// adds an inversion by extended Euclid and further multiplies, a doubling also
// its numerator. A finished result waits behind a stalled one. Reset returns
// the sequencer to idle, drops the result and restores both registers. A held
// result does not block the next input transaction.
`timescale 1ns / 1ps

module ec_point_add_prime_field (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  ecpa_pkg::ecpa_in_t                   in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output ecpa_pkg::ecpa_out_t                  out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ecpa_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [ecpa_pkg::FIELD_WIDTH-1:0]     cfg_data
);

  localparam int W  = ecpa_pkg::FIELD_WIDTH;
  localparam int CW = $clog2(W);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_R0   = 5'd1;
  localparam logic [4:0] S_R1   = 5'd2;
  localparam logic [4:0] S_R2   = 5'd3;
  localparam logic [4:0] S_R3   = 5'd4;
  localparam logic [4:0] S_R4   = 5'd5;
  localparam logic [4:0] S_CASE = 5'd6;
  localparam logic [4:0] S_D1   = 5'd7;
  localparam logic [4:0] S_D2   = 5'd8;
  localparam logic [4:0] S_D3   = 5'd9;
  localparam logic [4:0] S_INV  = 5'd10;
  localparam logic [4:0] S_EU   = 5'd11;
  localparam logic [4:0] S_DIV  = 5'd12;
  localparam logic [4:0] S_EUUP = 5'd13;
  localparam logic [4:0] S_L    = 5'd14;
  localparam logic [4:0] S_X1   = 5'd15;
  localparam logic [4:0] S_X2   = 5'd16;
  localparam logic [4:0] S_Y1   = 5'd17;
  localparam logic [4:0] S_Y2   = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;
  localparam logic [4:0] S_MUL  = 5'd20;

  logic [4:0]   state_r, state_nxt, ret_r, ret_nxt;
  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] modulus_r, curve_a_r;

  logic [W-1:0]  p_r, p_nxt;
  logic          inf1_r, inf1_nxt, inf2_r, inf2_nxt;
  logic [W-1:0]  x1_r, x1_nxt, y1_r, y1_nxt, x2_r, x2_nxt, y2_r, y2_nxt;
  logic [W-1:0]  a_r, a_nxt, lam_r, lam_nxt, den_r, den_nxt;
  logic [W-1:0]  mb_r, mb_nxt, mc_r, mc_nxt, acc_r, acc_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic          res_inf_r, res_inf_nxt;
  logic [W-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;
  ecpa_pkg::ecpa_out_t out_r, out_nxt;

  logic [W:0]    rem_t;
  logic          q_bit;
  logic          cnt_last;

  function automatic logic [W-1:0] add_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
    logic [W:0] s;
    s = {1'b0, u} + {1'b0, v};
    return (s >= {1'b0, p}) ? W'(s - {1'b0, p}) : s[W-1:0];
  endfunction

  function automatic logic [W-1:0] sub_mod(input logic [W-1:0] u, input logic [W-1:0] v,
                                           input logic [W-1:0] p);
    return (u >= v) ? (u - v) : (u - v + p);
  endfunction

  // One Horner step of acc*2 + bit*b, reduced; acc and b stay below p.
  function automatic logic [W-1:0] mod_step(input logic [W-1:0] acc, input logic b_bit,
                                            input logic [W-1:0] b, input logic [W-1:0] p);
    logic [W+1:0] t, p1, p2;
    t  = {1'b0, acc, 1'b0} + (b_bit ? {2'b00, b} : '0);
    p1 = {2'b00, p};
    p2 = {1'b0, p, 1'b0};
    if (t >= p2) begin
      return W'(t - p2);
    end else if (t >= p1) begin
      return W'(t - p1);
    end
    return t[W-1:0];
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  assign cnt_last = (cnt_r == CW'(W - 1));
  assign rem_t    = {rem_r, mb_r[W-1]};
  assign q_bit    = (rem_t >= {1'b0, r1_r});

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    out_valid_nxt = out_valid_r;
    p_nxt         = p_r;
    inf1_nxt      = inf1_r;
    inf2_nxt      = inf2_r;
    x1_nxt        = x1_r;
    y1_nxt        = y1_r;
    x2_nxt        = x2_r;
    y2_nxt        = y2_r;
    a_nxt         = a_r;
    lam_nxt       = lam_r;
    den_nxt       = den_r;
    mb_nxt        = mb_r;
    mc_nxt        = mc_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    r0_nxt        = r0_r;
    r1_nxt        = r1_r;
    t0_nxt        = t0_r;
    t1_nxt        = t1_r;
    rem_nxt       = rem_r;
    res_inf_nxt   = res_inf_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    out_nxt       = out_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          p_nxt    = (modulus_r < ecpa_pkg::MODULUS_MIN) ? ecpa_pkg::MODULUS_MIN : modulus_r;
          inf1_nxt = in_data.first_infinity;
          inf2_nxt = in_data.second_infinity;
          x1_nxt   = in_data.first_x;
          y1_nxt   = in_data.first_y;
          x2_nxt   = in_data.second_x;
          y2_nxt   = in_data.second_y;
          a_nxt    = curve_a_r;
          state_nxt = S_R0;
        end
      end
      // Reduce each operand as value * 1 through the step unit.
      S_R0: begin
        mb_nxt = x1_r; mc_nxt = W'(1); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_R1; state_nxt = S_MUL;
      end
      S_R1: begin
        x1_nxt = acc_r;
        mb_nxt = y1_r; mc_nxt = W'(1); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_R2; state_nxt = S_MUL;
      end
      S_R2: begin
        y1_nxt = acc_r;
        mb_nxt = x2_r; mc_nxt = W'(1); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_R3; state_nxt = S_MUL;
      end
      S_R3: begin
        x2_nxt = acc_r;
        mb_nxt = y2_r; mc_nxt = W'(1); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_R4; state_nxt = S_MUL;
      end
      S_R4: begin
        y2_nxt = acc_r;
        mb_nxt = a_r; mc_nxt = W'(1); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_CASE; state_nxt = S_MUL;
      end
      S_CASE: begin
        a_nxt       = acc_r;
        res_inf_nxt = 1'b0;
        if (inf1_r) begin
          res_inf_nxt = inf2_r; rx_nxt = x2_r; ry_nxt = y2_r;
          state_nxt = S_FIN;
        end else if (inf2_r) begin
          rx_nxt = x1_r; ry_nxt = y1_r;
          state_nxt = S_FIN;
        end else if (x1_r == x2_r && y1_r == y2_r) begin
          den_nxt = add_mod(y1_r, y1_r, p_r);
          if (add_mod(y1_r, y1_r, p_r) == '0) begin
            res_inf_nxt = 1'b1;
            state_nxt = S_FIN;
          end else begin
            mb_nxt = x1_r; mc_nxt = x1_r; acc_nxt = '0; cnt_nxt = '0;
            ret_nxt = S_D1; state_nxt = S_MUL;
          end
        end else if (x1_r == x2_r) begin
          res_inf_nxt = 1'b1;
          state_nxt = S_FIN;
        end else begin
          den_nxt = sub_mod(x2_r, x1_r, p_r);
          lam_nxt = sub_mod(y2_r, y1_r, p_r);
          state_nxt = S_INV;
        end
      end
      // Numerator 3x^2 + a, one addition a cycle.
      S_D1: begin
        lam_nxt = add_mod(acc_r, acc_r, p_r);
        state_nxt = S_D2;
      end
      S_D2: begin
        lam_nxt = add_mod(lam_r, acc_r, p_r);
        state_nxt = S_D3;
      end
      S_D3: begin
        lam_nxt = add_mod(lam_r, a_r, p_r);
        state_nxt = S_INV;
      end
      S_INV: begin
        r0_nxt = p_r; r1_nxt = den_r; t0_nxt = '0; t1_nxt = W'(1);
        state_nxt = S_EU;
      end
      // Bezout coefficients are carried modulo p, which leaves the final
      // reduced coefficient unchanged.
      S_EU: begin
        if (r1_r == '0) begin
          mb_nxt = lam_r; mc_nxt = t0_r; acc_nxt = '0; cnt_nxt = '0;
          ret_nxt = S_L; state_nxt = S_MUL;
        end else begin
          mb_nxt = r0_r; rem_nxt = '0; acc_nxt = '0; cnt_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      // Restoring divide of r0 by r1; quotient bits feed q*t1 mod p.
      S_DIV: begin
        rem_nxt = q_bit ? W'(rem_t - {1'b0, r1_r}) : rem_t[W-1:0];
        acc_nxt = mod_step(acc_r, q_bit, t1_r, p_r);
        mb_nxt  = {mb_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_last) begin
          state_nxt = S_EUUP;
        end
      end
      S_EUUP: begin
        r0_nxt = r1_r;
        r1_nxt = rem_r;
        t0_nxt = t1_r;
        t1_nxt = sub_mod(t0_r, acc_r, p_r);
        state_nxt = S_EU;
      end
      S_L: begin
        lam_nxt = acc_r;
        mb_nxt = acc_r; mc_nxt = acc_r; acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_X1; state_nxt = S_MUL;
      end
      // x2 equals x1 when doubling, so both cases subtract x1 and x2.
      S_X1: begin
        rx_nxt = sub_mod(acc_r, x1_r, p_r);
        state_nxt = S_X2;
      end
      S_X2: begin
        rx_nxt = sub_mod(rx_r, x2_r, p_r);
        state_nxt = S_Y1;
      end
      S_Y1: begin
        mb_nxt = lam_r; mc_nxt = sub_mod(x1_r, rx_r, p_r); acc_nxt = '0; cnt_nxt = '0;
        ret_nxt = S_Y2; state_nxt = S_MUL;
      end
      S_Y2: begin
        ry_nxt = sub_mod(acc_r, y1_r, p_r);
        state_nxt = S_FIN;
      end
      // Hold until the output register is free.
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt.sum_infinity = res_inf_r;
          out_nxt.sum_x        = res_inf_r ? '0 : rx_r;
          out_nxt.sum_y        = res_inf_r ? '0 : ry_r;
          out_valid_nxt        = 1'b1;
          state_nxt            = S_IDLE;
        end
      end
      S_MUL: begin
        acc_nxt = mod_step(acc_r, mb_r[W-1], mc_r, p_r);
        mb_nxt  = {mb_r[W-2:0], 1'b0};
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_last) begin
          state_nxt = ret_r;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= S_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= ecpa_pkg::MODULUS_RESET;
      curve_a_r   <= ecpa_pkg::CURVE_A_RESET;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          ecpa_pkg::REG_MODULUS: modulus_r <= cfg_data;
          ecpa_pkg::REG_CURVE_A: curve_a_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    p_r       <= p_nxt;
    inf1_r    <= inf1_nxt;
    inf2_r    <= inf2_nxt;
    x1_r      <= x1_nxt;
    y1_r      <= y1_nxt;
    x2_r      <= x2_nxt;
    y2_r      <= y2_nxt;
    a_r       <= a_nxt;
    lam_r     <= lam_nxt;
    den_r     <= den_nxt;
    mb_r      <= mb_nxt;
    mc_r      <= mc_nxt;
    acc_r     <= acc_nxt;
    cnt_r     <= cnt_nxt;
    r0_r      <= r0_nxt;
    r1_r      <= r1_nxt;
    t0_r      <= t0_nxt;
    t1_r      <= t1_nxt;
    rem_r     <= rem_nxt;
    res_inf_r <= res_inf_nxt;
    rx_r      <= rx_nxt;
    ry_r      <= ry_nxt;
    out_r     <= out_nxt;
  end

endmodule
